FILE: src/aml_s5_sleep_type_finder_top_defines.svh
// Assertion macros for the S5 sleep-type finder.
`ifndef AML_S5_SLEEP_TYPE_FINDER_TOP_DEFINES_SVH
`define AML_S5_SLEEP_TYPE_FINDER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define S5STF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define S5STF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/s5stf_pkg.sv
`timescale 1ns / 1ps

package s5stf_pkg;

    // Parse phases
    localparam logic [3:0] PH_SEARCH = 4'd0;
    localparam logic [3:0] PH_LEAD   = 4'd1;
    localparam logic [3:0] PH_SKIP   = 4'd2;
    localparam logic [3:0] PH_COUNT  = 4'd3;
    localparam logic [3:0] PH_A_OP   = 4'd4;
    localparam logic [3:0] PH_A_VAL  = 4'd5;
    localparam logic [3:0] PH_A_TAIL = 4'd6;
    localparam logic [3:0] PH_B_OP   = 4'd7;
    localparam logic [3:0] PH_B_VAL  = 4'd8;
    localparam logic [3:0] PH_B_TAIL = 4'd9;
    localparam logic [3:0] PH_DONE   = 4'd10;

    // Table opcodes
    localparam logic [7:0] OP_PACKAGE = 8'h12;
    localparam logic [7:0] OP_ZERO    = 8'h00;
    localparam logic [7:0] OP_ONE     = 8'h01;
    localparam logic [7:0] OP_ONES    = 8'hFF;
    localparam logic [7:0] OP_BYTE    = 8'h0A;
    localparam logic [7:0] OP_WORD    = 8'h0B;
    localparam logic [7:0] OP_DWORD   = 8'h0C;

    // Name characters
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_FIVE  = 8'h35;

    localparam int         WIN_DEPTH = 5;
    localparam logic [2:0] HIST_FULL = 3'(WIN_DEPTH);

    typedef struct packed {
        logic       found;
        logic [7:0] type_a;
        logic [7:0] type_b;
    } t_result;

    // 0x08 name op, 0x5C root, 0x2E dual name, 0x2F multi name:
    // 0x2E/0x2F differ only in bit 0.
    function automatic logic is_name_prefix(input logic [7:0] b);
        is_name_prefix = (b == 8'h08) || (b == 8'h5C) || (b[7:1] == 7'h17);
    endfunction

endpackage

FILE: src/s5stf_window.sv
`timescale 1ns / 1ps

// Five-byte history window and the "<prefix> _S5_ 0x12" match.
module s5stf_window (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    output logic       o_match
);

    logic [7:0] r_recent [0:s5stf_pkg::WIN_DEPTH-1];
    logic [2:0] r_hist;

    assign o_match = (r_hist == s5stf_pkg::HIST_FULL)
                  && (i_byte == s5stf_pkg::OP_PACKAGE)
                  && s5stf_pkg::is_name_prefix(r_recent[0])
                  && (r_recent[1] == s5stf_pkg::CH_UNDER)
                  && (r_recent[2] == s5stf_pkg::CH_S)
                  && (r_recent[3] == s5stf_pkg::CH_FIVE)
                  && (r_recent[4] == s5stf_pkg::CH_UNDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_clear)) begin
            for (int k = 0; k < s5stf_pkg::WIN_DEPTH; k++) begin
                r_recent[k] <= '0;
            end
            r_hist <= '0;
        end else if (i_take) begin
            for (int k = 0; k < s5stf_pkg::WIN_DEPTH - 1; k++) begin
                r_recent[k] <= r_recent[k+1];
            end
            r_recent[s5stf_pkg::WIN_DEPTH-1] <= i_byte;
            if (r_hist != s5stf_pkg::HIST_FULL) begin
                r_hist <= r_hist + 3'd1;
            end
        end
    end

endmodule

FILE: src/s5stf_parse.sv
`timescale 1ns / 1ps

// Package parse sequencer: length skip, element count, up to two integers.
module s5stf_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_last,
    input  logic [7:0]           i_byte,
    input  logic                 i_match,
    output s5stf_pkg::t_result   o_result
);

    logic [3:0] r_phase, n_phase;
    logic [1:0] r_skip,  n_skip;
    logic [7:0] r_count, n_count;
    logic [7:0] r_type_a, n_type_a;
    logic [7:0] r_type_b, n_type_b;
    logic       r_found, n_found;

    logic [3:0] w_after_a;
    logic       w_is_long;
    logic [1:0] w_op_skip;
    logic [7:0] w_op_value;

    assign w_after_a = (r_count >= 8'd2) ? s5stf_pkg::PH_B_OP : s5stf_pkg::PH_DONE;
    assign w_is_long = (i_byte == s5stf_pkg::OP_BYTE) || (i_byte == s5stf_pkg::OP_WORD)
                    || (i_byte == s5stf_pkg::OP_DWORD);

    always_comb begin
        priority if (i_byte == s5stf_pkg::OP_WORD) begin
            w_op_skip = 2'd1;
        end else if (i_byte == s5stf_pkg::OP_DWORD) begin
            w_op_skip = 2'd3;
        end else begin
            w_op_skip = 2'd0;
        end
        priority if (i_byte == s5stf_pkg::OP_ONE) begin
            w_op_value = 8'h01;
        end else if (i_byte == s5stf_pkg::OP_ONES) begin
            w_op_value = 8'hFF;
        end else begin
            w_op_value = 8'h00;   // zero op and unknown ops
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_count  = r_count;
        n_type_a = r_type_a;
        n_type_b = r_type_b;
        n_found  = r_found;
        unique case (r_phase)
            s5stf_pkg::PH_SEARCH: begin
                if (i_match) begin
                    n_phase = s5stf_pkg::PH_LEAD;
                end
            end
            s5stf_pkg::PH_LEAD: begin
                n_skip  = i_byte[7:6];
                n_phase = (i_byte[7:6] != 2'd0) ? s5stf_pkg::PH_SKIP : s5stf_pkg::PH_COUNT;
            end
            s5stf_pkg::PH_SKIP: begin
                n_skip = r_skip - 2'd1;
                if (r_skip == 2'd1) begin
                    n_phase = s5stf_pkg::PH_COUNT;
                end
            end
            s5stf_pkg::PH_COUNT: begin
                n_count = i_byte;
                if (i_byte == 8'd0) begin
                    n_phase = s5stf_pkg::PH_DONE;
                end else begin
                    n_found = 1'b1;
                    n_phase = s5stf_pkg::PH_A_OP;
                end
            end
            s5stf_pkg::PH_A_OP: begin
                if (w_is_long) begin
                    n_skip  = w_op_skip;
                    n_phase = s5stf_pkg::PH_A_VAL;
                end else begin
                    n_type_a = w_op_value;
                    n_phase  = w_after_a;
                end
            end
            s5stf_pkg::PH_B_OP: begin
                if (w_is_long) begin
                    n_skip  = w_op_skip;
                    n_phase = s5stf_pkg::PH_B_VAL;
                end else begin
                    n_type_b = w_op_value;
                    n_phase  = s5stf_pkg::PH_DONE;
                end
            end
            s5stf_pkg::PH_A_VAL: begin
                n_type_a = i_byte;
                n_phase  = (r_skip != 2'd0) ? s5stf_pkg::PH_A_TAIL : w_after_a;
            end
            s5stf_pkg::PH_B_VAL: begin
                n_type_b = i_byte;
                n_phase  = (r_skip != 2'd0) ? s5stf_pkg::PH_B_TAIL : s5stf_pkg::PH_DONE;
            end
            s5stf_pkg::PH_A_TAIL: begin
                n_skip = r_skip - 2'd1;
                if (r_skip == 2'd1) begin
                    n_phase = w_after_a;
                end
            end
            s5stf_pkg::PH_B_TAIL: begin
                n_skip = r_skip - 2'd1;
                if (r_skip == 2'd1) begin
                    n_phase = s5stf_pkg::PH_DONE;
                end
            end
            default: begin
                // decided or unused code: bytes ignored
            end
        endcase
    end

    // Result reflects the state after this byte.
    assign o_result.found  = n_found;
    assign o_result.type_a = n_found ? n_type_a : 8'h00;
    assign o_result.type_b = n_found ? n_type_b : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase  <= s5stf_pkg::PH_SEARCH;
            r_skip   <= '0;
            r_count  <= '0;
            r_type_a <= '0;
            r_type_b <= '0;
            r_found  <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_count  <= n_count;
            r_type_a <= n_type_a;
            r_type_b <= n_type_b;
            r_found  <= n_found;
        end
    end

endmodule

FILE: src/s5stf_obuf.sv
`timescale 1ns / 1ps

// Two-entry result buffer: output register plus skid entry.
module s5stf_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  s5stf_pkg::t_result i_result,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output s5stf_pkg::t_result o_result
);

    logic               r_main_v, r_skid_v;
    s5stf_pkg::t_result r_main, r_skid;
    logic               w_pop;

    assign w_pop    = r_main_v && i_ready;
    assign o_space  = !r_skid_v;
    assign o_valid  = r_main_v;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_pop) begin
                r_main_v <= r_skid_v || i_push;
                r_skid_v <= 1'b0;
            end else if (i_push) begin
                r_main_v <= 1'b1;
                r_skid_v <= r_main_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_main <= r_skid_v ? r_skid : i_result;
        end else if (i_push && !r_main_v) begin
            r_main <= i_result;
        end
        if (i_push && r_main_v && !w_pop) begin
            r_skid <= i_result;
        end
    end

endmodule

FILE: src/aml_s5_sleep_type_finder_top.sv
`timescale 1ns / 1ps
// S5 sleep-type finder.
// Slave stream: one table-body byte per item in i_s_tdata, i_s_tlast marks
// the final byte of the table. Master stream: one item per table, issued
// after its last byte: o_m_tuser[0] = found, o_m_tdata = {type_b, type_a}.
// The block looks for the first "_S5_" name preceded by a name prefix and
// followed by a package opcode, skips the package length, reads the element
// count and decodes one or two integer elements, keeping their low bytes.
// Not found (short table, zero count, end before the count) gives zeros.
// Throughput: one byte per cycle while o_s_tready is high; each byte
// needs only the five-byte window compare and one step of the parse sequencer.
// Latency: the result appears on o_m_tvalid the cycle after the last byte
// is accepted when the buffer is empty; otherwise it waits until the result
// ahead of it has been taken. A two-entry output buffer (register plus skid)
// lets input keep flowing while a result waits; o_s_tready drops only when
// two results are pending, i.e. when the receiver stalls across two table ends.
// Reset (synchronous, active low) empties the buffer and returns the
// window and parser to the search state; the parser also returns there
// after every last byte, ready for the next table.
`include "aml_s5_sleep_type_finder_top_defines.svh"

module aml_s5_sleep_type_finder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] sleep_type_a, [15:8] sleep_type_b
    output logic [0:0]  o_m_tuser    // [0] found
);

    logic               w_take;
    logic               w_match;
    s5stf_pkg::t_result w_result;
    s5stf_pkg::t_result w_out;

    assign w_take = i_s_tvalid && o_s_tready;

    s5stf_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_clear (i_s_tlast),
        .i_byte  (i_s_tdata),
        .o_match (w_match)
    );

    s5stf_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_last   (i_s_tlast),
        .i_byte   (i_s_tdata),
        .i_match  (w_match),
        .o_result (w_result)
    );

    s5stf_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_take && i_s_tlast),
        .i_result (w_result),
        .o_space  (o_s_tready),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_out)
    );

    assign o_m_tdata = {w_out.type_b, w_out.type_a};
    assign o_m_tuser = w_out.found;

    // Assertions
    `S5STF_ASSERT_SAME(a_full_has_main, !o_s_tready, o_m_tvalid, "skid full without main entry")
    `S5STF_ASSERT_SAME(a_notfound_zero, o_m_tvalid && !o_m_tuser[0], o_m_tdata == 16'h0000,
                       "not-found result carries nonzero types")
    `S5STF_ASSERT_NEXT(a_last_gives_out, w_take && i_s_tlast, o_m_tvalid,
                       "last byte produced no result")

endmodule

FILE: tb/s5stf_tb_pkg.sv
`timescale 1ns / 1ps

package s5stf_tb_pkg;

    // Bytes that may stand just before the _S5_ name
    localparam logic [7:0] PFX_NAME_OP = 8'h08;
    localparam logic [7:0] PFX_ROOT    = 8'h5C;
    localparam logic [7:0] PFX_DUAL    = 8'h2E;
    localparam logic [7:0] PFX_MULTI   = 8'h2F;

endpackage

FILE: tb/s5_sleep_type_checker.sv
`timescale 1ns / 1ps

module s5_sleep_type_checker
    import s5stf_pkg::*;
    import s5stf_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_found_count
);

    localparam int REPORT_LIMIT = 10;

    // parser copy
    logic [7:0] win [WIN_DEPTH];
    logic [2:0] win_fill;
    logic [3:0] phase;
    logic [1:0] bytes_to_skip;
    logic [7:0] elem_count;
    logic [7:0] held_a;
    logic [7:0] held_b;
    logic       pkg_found;

    t_result sleep_types_due[$];
    int      fails;
    int      checked;
    int      found_seen;

    function automatic void clear_parser();
        for (int k = 0; k < WIN_DEPTH; k++) win[k] = 8'h00;
        win_fill      = 3'd0;
        phase         = PH_SEARCH;
        bytes_to_skip = 2'd0;
        elem_count    = 8'h00;
        held_a        = 8'h00;
        held_b        = 8'h00;
        pkg_found     = 1'b0;
    endfunction

    function automatic logic is_prefix_byte(input logic [7:0] b);
        return b == PFX_NAME_OP || b == PFX_ROOT || b == PFX_DUAL || b == PFX_MULTI;
    endfunction

    function automatic logic [3:0] end_of_element(input logic second);
        return (!second && elem_count >= 8'd2) ? PH_B_OP : PH_DONE;
    endfunction

    // integer opcode: either a value follows, or the value is implied
    function automatic logic [3:0] take_int_op(input logic [7:0] op, input logic second);
        logic [7:0] v;
        v = 8'h00;
        case (op)
            OP_BYTE: begin
                bytes_to_skip = 2'd0;
                return second ? PH_B_VAL : PH_A_VAL;
            end
            OP_WORD: begin
                bytes_to_skip = 2'd1;
                return second ? PH_B_VAL : PH_A_VAL;
            end
            OP_DWORD: begin
                bytes_to_skip = 2'd3;
                return second ? PH_B_VAL : PH_A_VAL;
            end
            OP_ONE:  v = 8'h01;
            OP_ONES: v = 8'hFF;
            default: v = 8'h00;
        endcase
        if (second)
            held_b = v;
        else
            held_a = v;
        return end_of_element(second);
    endfunction

    function automatic void step_parser(input logic [7:0] b);
        case (phase)
            PH_SEARCH: begin
                if (win_fill >= HIST_FULL && b == OP_PACKAGE && is_prefix_byte(win[0]) &&
                    win[1] == CH_UNDER && win[2] == CH_S && win[3] == CH_FIVE &&
                    win[4] == CH_UNDER)
                    phase = PH_LEAD;
            end
            PH_LEAD: begin
                bytes_to_skip = b[7:6];
                phase = (b[7:6] != 2'd0) ? PH_SKIP : PH_COUNT;
            end
            PH_SKIP: begin
                bytes_to_skip = bytes_to_skip - 2'd1;
                if (bytes_to_skip == 2'd0)
                    phase = PH_COUNT;
            end
            PH_COUNT: begin
                elem_count = b;
                if (b == 8'h00) begin
                    phase = PH_DONE;
                end else begin
                    pkg_found = 1'b1;
                    phase = PH_A_OP;
                end
            end
            PH_A_OP: phase = take_int_op(b, 1'b0);
            PH_B_OP: phase = take_int_op(b, 1'b1);
            PH_A_VAL: begin
                held_a = b;
                phase = (bytes_to_skip != 2'd0) ? PH_A_TAIL : end_of_element(1'b0);
            end
            PH_B_VAL: begin
                held_b = b;
                phase = (bytes_to_skip != 2'd0) ? PH_B_TAIL : end_of_element(1'b1);
            end
            PH_A_TAIL: begin
                bytes_to_skip = bytes_to_skip - 2'd1;
                if (bytes_to_skip == 2'd0)
                    phase = end_of_element(1'b0);
            end
            PH_B_TAIL: begin
                bytes_to_skip = bytes_to_skip - 2'd1;
                if (bytes_to_skip == 2'd0)
                    phase = end_of_element(1'b1);
            end
            default: ;
        endcase
        for (int k = 0; k < WIN_DEPTH - 1; k++) win[k] = win[k + 1];
        win[WIN_DEPTH - 1] = b;
        if (win_fill < HIST_FULL)
            win_fill = win_fill + 3'd1;
    endfunction

    initial clear_parser();

    always @(posedge i_clk) begin : watch
        t_result due_r;
        t_result got_r;
        if (!i_rst_n) begin
            clear_parser();
            sleep_types_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                step_parser(i_s_tdata);
                if (i_s_tlast) begin
                    due_r.found  = pkg_found;
                    due_r.type_a = pkg_found ? held_a : 8'h00;
                    due_r.type_b = pkg_found ? held_b : 8'h00;
                    sleep_types_due.push_back(due_r);
                    clear_parser();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got_r.found  = i_m_tuser[0];
                got_r.type_a = i_m_tdata[7:0];
                got_r.type_b = i_m_tdata[15:8];
                if (sleep_types_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: unexpected result found=%0b a=%02h b=%02h", $realtime,
                                 got_r.found, got_r.type_a, got_r.type_b);
                end else begin
                    due_r = sleep_types_due.pop_front();
                    checked++;
                    if (got_r.found)
                        found_seen++;
                    if (got_r.found != due_r.found || got_r.type_a != due_r.type_a ||
                        got_r.type_b != due_r.type_b) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: result %0d expected found=%0b a=%02h b=%02h",
                                     $realtime, checked, due_r.found, due_r.type_a,
                                     due_r.type_b);
                            $display("%0t: result %0d got      found=%0b a=%02h b=%02h",
                                     $realtime, checked, got_r.found, got_r.type_a,
                                     got_r.type_b);
                        end
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= sleep_types_due.size();
        o_checked     <= checked;
        o_found_count <= found_seen;
    end

endmodule

FILE: tb/aml_s5_sleep_type_finder_top_tb.sv
`timescale 1ns / 1ps

module aml_s5_sleep_type_finder_top_tb;
    import s5stf_pkg::*;
    import s5stf_tb_pkg::*;

    localparam int  BYTE_TARGET    = 650;   // stop offering new tables past this
    localparam int  TABLE_TARGET   = 40;    // ... and past this many tables
    localparam int  IDLE_PCT       = 11;    // chance of a gap / stall per cycle
    localparam int  RX_HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int  HOLD_AT_TABLE  = 30;
    localparam int  QUIET_FIRST    = 15;    // tables [QUIET_FIRST, QUIET_LAST) run gap-free
    localparam int  QUIET_LAST     = 25;
    localparam int  TAIL_CYCLES    = 10;    // margin waited after the drain
    localparam time LIMIT_NS       = 1ms;

    logic        i_clk = 1'b0;
    logic        rst_n;

    // slave side (into the block)
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] data_byte
    logic        s_tlast;      // last_byte
    // master side (out of the block)
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [7:0] sleep_type_a, [15:8] sleep_type_b
    logic [0:0]  m_tuser;      // [0] found

    int          fail_count;
    int          pending;
    int          checked;
    int          found_count;

    // stimulus state
    logic [7:0]  table_bytes[$];
    int          bytes_sent;
    int          tables_sent;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;     // set by the sender side only
    bit          hold_done = 1'b0;    // set by the receiver side only

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    aml_s5_sleep_type_finder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    s5_sleep_type_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_found_count (found_count)
    );

    // Byte that is either random or one of the interesting ones, so that
    // partial names and stray package opcodes turn up in the noise.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(15))
            0:       return CH_UNDER;
            1:       return CH_S;
            2:       return CH_FIVE;
            3:       return OP_PACKAGE;
            4:       return PFX_NAME_OP;
            5:       return PFX_ROOT;
            6:       return PFX_DUAL;
            7:       return PFX_MULTI;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_prefix();
        case ($urandom_range(3))
            0:       return PFX_NAME_OP;
            1:       return PFX_ROOT;
            2:       return PFX_DUAL;
            default: return PFX_MULTI;
        endcase
    endfunction

    function automatic logic [7:0] pick_int_op();
        case ($urandom_range(6))
            0:       return OP_ZERO;
            1:       return OP_ONE;
            2:       return OP_ONES;
            3:       return OP_BYTE;
            4:       return OP_WORD;
            5:       return OP_DWORD;
            default: return 8'($urandom_range(255));   // mostly unknown opcodes
        endcase
    endfunction

    function automatic void push_name(input logic [7:0] pfx, input logic [7:0] op);
        table_bytes.push_back(pfx);
        table_bytes.push_back(CH_UNDER);
        table_bytes.push_back(CH_S);
        table_bytes.push_back(CH_FIVE);
        table_bytes.push_back(CH_UNDER);
        table_bytes.push_back(op);
    endfunction

    // One table body. Mostly well-formed S5 packages with random content;
    // some pure noise, some decoy names, some cut short at a random point.
    function automatic void make_table();
        int         shape;
        int         pick;
        int         n_elem;
        int         cut;
        logic [7:0] lead;
        logic [7:0] count;
        logic [7:0] op;
        table_bytes.delete();
        shape = $urandom_range(99);
        if (shape < 15) begin
            repeat ($urandom_range(1, 16)) table_bytes.push_back(noise_byte());
            return;
        end
        repeat ($urandom_range(0, 4)) table_bytes.push_back(noise_byte());
        // decoy: bad prefix or bad opcode after the name
        if (shape < 25) begin
            if ($urandom_range(1))
                push_name(8'($urandom_range(255)), OP_PACKAGE);
            else
                push_name(pick_prefix(), noise_byte());
        end
        push_name(pick_prefix(), OP_PACKAGE);
        lead = 8'($urandom_range(255));
        table_bytes.push_back(lead);
        repeat (int'(lead[7:6])) table_bytes.push_back(8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 10)
            count = 8'h00;
        else if (pick < 40)
            count = 8'h01;
        else if (pick < 85)
            count = 8'h02;
        else
            count = 8'($urandom_range(3, 255));
        table_bytes.push_back(count);
        n_elem = (count == 8'h00) ? 0 : (count >= 8'h02) ? 2 : 1;
        for (int e = 0; e < n_elem; e++) begin
            op = pick_int_op();
            table_bytes.push_back(op);
            case (op)
                OP_BYTE:  table_bytes.push_back(8'($urandom_range(255)));
                OP_WORD:  repeat (2) table_bytes.push_back(8'($urandom_range(255)));
                OP_DWORD: repeat (4) table_bytes.push_back(8'($urandom_range(255)));
                default: ;
            endcase
        end
        // trailing bytes, sometimes a second package that must be ignored
        if ($urandom_range(9) == 0) begin
            push_name(pick_prefix(), OP_PACKAGE);
            table_bytes.push_back(8'h00);
            table_bytes.push_back(8'h02);
            table_bytes.push_back(OP_ONES);
            table_bytes.push_back(OP_ONE);
        end
        repeat ($urandom_range(0, 3)) table_bytes.push_back(noise_byte());
        // early end anywhere
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(1, table_bytes.size());
            while (table_bytes.size() > cut) void'(table_bytes.pop_back());
        end
    endfunction

    // Offer the table one byte per item; tlast on the final one. tvalid
    // stays high between back-to-back items.
    task automatic send_table();
        for (int k = 0; k < table_bytes.size(); k++) begin
            if (gaps_on) begin
                while ($urandom_range(99) < IDLE_PCT) begin
                    s_tvalid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= table_bytes[k];
            s_tlast  <= (k == table_bytes.size() - 1);
            do @(posedge i_clk); while (!s_tready);
            bytes_sent++;
        end
        tables_sent++;
    endtask

    // wait until every predicted result has been taken by the receiver
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: random stalls, plus one long hold-off so that two results
    // pile up in the block and it must drop s_tready.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                for (int c = 0; c < RX_HOLD_CYCLES; c++) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Sender and verdict
    initial begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-byte table, stream ending on the package opcode,
        // stream ending on the lead byte, then a full two-element package.
        table_bytes = '{8'hFF};
        send_table();
        table_bytes.delete();
        push_name(PFX_NAME_OP, OP_PACKAGE);
        send_table();
        table_bytes.delete();
        push_name(PFX_ROOT, OP_PACKAGE);
        table_bytes.push_back(8'h00);
        send_table();
        table_bytes.delete();
        push_name(PFX_MULTI, OP_PACKAGE);
        table_bytes.push_back(8'h05);
        table_bytes.push_back(8'h02);
        table_bytes.push_back(OP_BYTE);
        table_bytes.push_back(8'h05);
        table_bytes.push_back(OP_ONES);
        send_table();

        // sender pause: let the block drain completely
        s_tvalid <= 1'b0;
        wait_drained();

        // Random tables; a gap-free stretch, and the long receiver hold-off
        // started while the sender keeps going.
        for (int t = 0; bytes_sent < BYTE_TARGET || tables_sent < TABLE_TARGET; t++) begin
            gaps_on = !(t >= QUIET_FIRST && t < QUIET_LAST);
            if (t == HOLD_AT_TABLE)
                hold_req = 1'b1;
            make_table();
            send_table();
        end
        s_tvalid <= 1'b0;
        gaps_on = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d tables in %0d bytes; %0d results checked, %0d with S5 found.",
                 tables_sent, bytes_sent, checked, found_count);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hard stop in case a handshake hangs
    initial begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
